FILE: design/per_channel_command_ring_core_defines.svh
// Assertion macros for the per-channel command ring.
// Used by the checker bound to per_channel_command_ring_core; expects clk and rst in scope.
`ifndef PER_CHANNEL_COMMAND_RING_CORE_DEFINES_SVH
`define PER_CHANNEL_COMMAND_RING_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/pccr_pkg.sv
// Shared types and constants for the per-channel command ring.
// No dependencies; used by the store, the core and the checker.
package pccr_pkg;

  localparam int TIME_W = 63;
  localparam int PAY_W  = 64;
  localparam int CMD_W  = 3;
  localparam int CHP_W  = 3;
  localparam int SIZE_W = 16;
  localparam int DCNT_W = 7;
  localparam int WCNT_W = 32;
  localparam int RCNT_W = 33;

  typedef enum logic [CMD_W-1:0] {
    CMD_RECEIVE     = 3'd0,
    CMD_READ_NEXT   = 3'd1,
    CMD_READ_NEWEST = 3'd2,
    CMD_RESET       = 3'd3,
    CMD_DUMP        = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [PAY_W-1:0]  data;
  } entry_t;

endpackage

FILE: design/per_channel_command_ring_core.sv
// Per-channel command ring: one ring of timestamped entries per channel.
// Usage:
//   Input channel (in_valid/in_stall) carries one command beat: receive,
//   read next, read newest, reset channel or dump recent. Output channel
//   (out_valid/out_stall) returns result beats; last_of_run marks the final
//   beat of each command.
//   One command is in work at a time; in_stall is high while it is planned,
//   but the block goes back to taking commands as soon as its last result sits
//   in the output register.
//   Receive, reset, empty dump and ignored commands: the result is registered
//   in the plan state. Read next / read newest: a load state follows for the
//   registered memory read. A dump is paced by the single read port of the
//   entry store: each slot is read, then presented, before the next is read.
//   A stalled receiver holds the output beat; the sequencer waits on it.
//   Reset empties every ring at once: per-channel write pointers and a
//   wrapped flag mark which slots were written, so no clearing pass runs and
//   never-written slots read as zero.
module per_channel_command_ring_core #(
  parameter int CHANNELS   = 8,
  parameter int RING_DEPTH = 64,
  parameter int MAX_SEND   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pccr_pkg::CMD_W-1:0]    cmd,
  input  logic [pccr_pkg::CHP_W-1:0]    channel,
  input  logic [pccr_pkg::TIME_W-1:0]   entry_time,
  input  logic [pccr_pkg::PAY_W-1:0]    entry_payload,
  input  logic [pccr_pkg::SIZE_W-1:0]   batch_size,
  input  logic [pccr_pkg::SIZE_W-1:0]   dump_limit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          has_entry,
  output logic [pccr_pkg::TIME_W-1:0]   out_time,
  output logic [pccr_pkg::PAY_W-1:0]    out_payload,
  output logic                          accepted,
  output logic [pccr_pkg::DCNT_W-1:0]   dump_count,
  output logic                          last_of_run
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int AW    = $clog2(CHANNELS * RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_PLAN, S_DREAD, S_LOAD} state_t;

  state_t state;

  // latched command beat
  logic [pccr_pkg::CMD_W-1:0]  cmd_q;
  logic [pccr_pkg::CHP_W-1:0]  ch_q;
  logic [pccr_pkg::TIME_W-1:0] time_q;
  logic [pccr_pkg::PAY_W-1:0]  pay_q;
  logic [pccr_pkg::SIZE_W-1:0] batch_q;
  logic [pccr_pkg::SIZE_W-1:0] lim_q;

  // per-channel ring state
  logic [pccr_pkg::WCNT_W-1:0] wcount [CHANNELS];
  logic [pccr_pkg::RCNT_W-1:0] rcount [CHANNELS];
  logic [pccr_pkg::TIME_W-1:0] newest [CHANNELS];
  logic [PTR_W-1:0]            wptr   [CHANNELS];
  logic [PTR_W-1:0]            rptr   [CHANNELS];
  logic                        full   [CHANNELS];

  // dump walk and read bookkeeping
  logic                        dumping;
  logic [pccr_pkg::DCNT_W-1:0] dump_n;
  logic [pccr_pkg::DCNT_W-1:0] dump_left;
  logic [PTR_W-1:0]            dump_ptr;
  logic                        rd_has;
  logic                        rd_written;

  // combinational view of the addressed channel
  logic [CH_W-1:0]             ch_idx;
  logic                        chan_ok;
  logic                        out_free;
  logic [pccr_pkg::WCNT_W-1:0] cur_w;
  logic [pccr_pkg::RCNT_W-1:0] cur_r;
  logic [pccr_pkg::TIME_W-1:0] cur_newest;
  logic [PTR_W-1:0]            cur_wp;
  logic [PTR_W-1:0]            cur_rp;
  logic                        cur_full;
  logic                        recv_ok;
  logic [PTR_W-1:0]            wp_inc;
  logic [pccr_pkg::RCNT_W-1:0] wm1;
  logic                        r_adv;
  logic [pccr_pkg::RCNT_W-1:0] r_new;
  logic [PTR_W-1:0]            rp_new;
  logic [PTR_W-1:0]            nw_ptr;
  logic [31:0]                 n32;
  logic [PTR_W:0]              n_p;
  logic [PTR_W-1:0]            start_ptr;
  logic [PTR_W-1:0]            dump_ptr_inc;
  logic [PTR_W-1:0]            mem_ptr;
  logic                        mem_wr_en;
  logic                        mem_rd_en;
  logic [AW-1:0]               mem_addr;
  logic                        slot_written;
  pccr_pkg::entry_t            wr_entry;
  pccr_pkg::entry_t            rd_entry;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    ch_idx     = CH_W'(ch_q);
    chan_ok    = (32'(ch_q) < 32'(CHANNELS));
    cur_w      = wcount[ch_idx];
    cur_r      = rcount[ch_idx];
    cur_newest = newest[ch_idx];
    cur_wp     = wptr[ch_idx];
    cur_rp     = rptr[ch_idx];
    cur_full   = full[ch_idx];

    recv_ok = (batch_q != '0) && (32'(batch_q) <= 32'(MAX_SEND)) && (time_q > cur_newest);
    // the ring pointer also restarts when the 32-bit write count wraps
    wp_inc  = (cur_wp == PTR_LAST || cur_w == '1) ? '0 : cur_wp + PTR_W'(1);

    wm1    = {1'b0, cur_w} - pccr_pkg::RCNT_W'(1);
    r_adv  = $signed(cur_r) < $signed(wm1);
    r_new  = r_adv ? cur_r + pccr_pkg::RCNT_W'(1) : cur_r;
    if (!r_adv) begin
      rp_new = cur_rp;
    end else if (cur_r[pccr_pkg::RCNT_W-1] || cur_rp == PTR_LAST) begin
      rp_new = '0;
    end else begin
      rp_new = cur_rp + PTR_W'(1);
    end

    nw_ptr = (cur_wp == '0) ? PTR_LAST : cur_wp - PTR_W'(1);

    // clamp the dump length
    n32 = {16'b0, lim_q};
    if (n32 > 32'(MAX_SEND)) begin
      n32 = 32'(MAX_SEND);
    end
    if (n32 > 32'(RING_DEPTH)) begin
      n32 = 32'(RING_DEPTH);
    end
    if (n32 > cur_w) begin
      n32 = cur_w;
    end
    n_p = (PTR_W+1)'(n32);
    if ({1'b0, cur_wp} >= n_p) begin
      start_ptr = PTR_W'({1'b0, cur_wp} - n_p);
    end else begin
      start_ptr = PTR_W'({1'b0, cur_wp} + (PTR_W+1)'(RING_DEPTH) - n_p);
    end
    dump_ptr_inc = (dump_ptr == PTR_LAST) ? '0 : dump_ptr + PTR_W'(1);

    mem_wr_en = 1'b0;
    mem_rd_en = 1'b0;
    mem_ptr   = '0;
    case (state)
      S_PLAN: begin
        if (out_free && chan_ok) begin
          case (cmd_q)
            pccr_pkg::CMD_RECEIVE: begin
              mem_wr_en = recv_ok;
              mem_ptr   = cur_wp;
            end
            pccr_pkg::CMD_READ_NEXT: begin
              mem_rd_en = 1'b1;
              mem_ptr   = r_new[pccr_pkg::RCNT_W-1] ? '0 : rp_new;
            end
            pccr_pkg::CMD_READ_NEWEST: begin
              mem_rd_en = 1'b1;
              mem_ptr   = (cur_w == '0) ? '0 : nw_ptr;
            end
            pccr_pkg::CMD_DUMP: begin
              mem_rd_en = (n32 != '0);
              mem_ptr   = start_ptr;
            end
            default: begin
              mem_rd_en = 1'b0;
            end
          endcase
        end
      end
      S_DREAD: begin
        mem_rd_en = out_free;
        mem_ptr   = dump_ptr;
      end
      default: begin
        mem_rd_en = 1'b0;
      end
    endcase

    mem_addr     = AW'(32'(ch_idx) * RING_DEPTH) + AW'(mem_ptr);
    // a slot holds data once the ring has wrapped or the pointer has passed it
    slot_written = cur_full || (mem_ptr < cur_wp);
    wr_entry     = '{stamp: time_q, data: pay_q};
  end

  pccr_store #(
    .CHANNELS   (CHANNELS),
    .RING_DEPTH (RING_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .rd_en   (mem_rd_en),
    .addr    (mem_addr),
    .wr_data (wr_entry),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      dumping   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wcount[i] <= '0;
        rcount[i] <= '1;
        newest[i] <= '0;
        wptr[i]   <= '0;
        rptr[i]   <= '0;
        full[i]   <= 1'b0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (mem_rd_en) begin
        rd_written <= slot_written;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q   <= cmd;
            ch_q    <= channel;
            time_q  <= entry_time;
            pay_q   <= entry_payload;
            batch_q <= batch_size;
            lim_q   <= dump_limit;
            state   <= S_PLAN;
          end
        end

        S_PLAN: begin
          if (out_free) begin
            // default: single empty result, then back to idle
            state       <= S_IDLE;
            out_valid   <= 1'b1;
            has_entry   <= 1'b0;
            out_time    <= '0;
            out_payload <= '0;
            accepted    <= 1'b0;
            dump_count  <= '0;
            last_of_run <= 1'b1;
            if (chan_ok) begin
              case (cmd_q)
                pccr_pkg::CMD_RECEIVE: begin
                  accepted <= recv_ok;
                  if (recv_ok) begin
                    wcount[ch_idx] <= cur_w + pccr_pkg::WCNT_W'(1);
                    newest[ch_idx] <= time_q;
                    wptr[ch_idx]   <= wp_inc;
                    if (wp_inc == '0) begin
                      full[ch_idx] <= 1'b1;
                    end
                  end
                end
                pccr_pkg::CMD_READ_NEXT: begin
                  rcount[ch_idx] <= r_new;
                  rptr[ch_idx]   <= rp_new;
                  rd_has         <= !r_new[pccr_pkg::RCNT_W-1];
                  dumping        <= 1'b0;
                  out_valid      <= 1'b0;
                  state          <= S_LOAD;
                end
                pccr_pkg::CMD_READ_NEWEST: begin
                  rd_has    <= (cur_w != '0);
                  dumping   <= 1'b0;
                  out_valid <= 1'b0;
                  state     <= S_LOAD;
                end
                pccr_pkg::CMD_RESET: begin
                  wcount[ch_idx] <= '0;
                  rcount[ch_idx] <= '1;
                  newest[ch_idx] <= '0;
                  wptr[ch_idx]   <= '0;
                  rptr[ch_idx]   <= '0;
                  full[ch_idx]   <= 1'b0;
                end
                pccr_pkg::CMD_DUMP: begin
                  if (n32 != '0) begin
                    dump_n    <= pccr_pkg::DCNT_W'(n32);
                    dump_left <= pccr_pkg::DCNT_W'(n32);
                    dump_ptr  <= start_ptr;
                    dumping   <= 1'b1;
                    rd_has    <= 1'b1;
                    out_valid <= 1'b0;
                    state     <= S_LOAD;
                  end
                end
                default: begin
                  accepted <= 1'b0;
                end
              endcase
            end
          end
        end

        S_LOAD: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            has_entry   <= rd_has;
            out_time    <= rd_written ? rd_entry.stamp : '0;
            out_payload <= rd_written ? rd_entry.data : '0;
            accepted    <= 1'b0;
            dump_count  <= dumping ? dump_n : '0;
            last_of_run <= !dumping || (dump_left == pccr_pkg::DCNT_W'(1));
            if (dumping && dump_left != pccr_pkg::DCNT_W'(1)) begin
              // advance to the next slot of the run
              dump_left <= dump_left - pccr_pkg::DCNT_W'(1);
              dump_ptr  <= dump_ptr_inc;
              state     <= S_DREAD;
            end else begin
              dumping <= 1'b0;
              state   <= S_IDLE;
            end
          end
        end

        S_DREAD: begin
          if (out_free) begin
            state <= S_LOAD;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/pccr_store.sv
// Entry store: one flat memory holding every channel's ring slots.
// Single address port, registered read data; depends on pccr_pkg.
module pccr_store #(
  parameter int CHANNELS   = 8,
  parameter int RING_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic                                  rd_en,
  input  logic [$clog2(CHANNELS*RING_DEPTH)-1:0] addr,
  input  pccr_pkg::entry_t                      wr_data,
  output pccr_pkg::entry_t                      rd_data
);

  localparam int DEPTH = CHANNELS * RING_DEPTH;

  pccr_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

FILE: design/pccr_checker.sv
// Port-level checker for per_channel_command_ring_core, bound to the top level.
// Depends on pccr_pkg and per_channel_command_ring_core_defines.svh.
`include "per_channel_command_ring_core_defines.svh"

module pccr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [pccr_pkg::CMD_W-1:0]    cmd,
  input logic [pccr_pkg::CHP_W-1:0]    channel,
  input logic [pccr_pkg::TIME_W-1:0]   entry_time,
  input logic [pccr_pkg::PAY_W-1:0]    entry_payload,
  input logic [pccr_pkg::SIZE_W-1:0]   batch_size,
  input logic [pccr_pkg::SIZE_W-1:0]   dump_limit,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          has_entry,
  input logic [pccr_pkg::TIME_W-1:0]   out_time,
  input logic [pccr_pkg::PAY_W-1:0]    out_payload,
  input logic                          accepted,
  input logic [pccr_pkg::DCNT_W-1:0]   dump_count,
  input logic                          last_of_run
);

  // hold a stalled result beat
  `PCCR_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(out_time) && $stable(out_payload) && $stable(dump_count) && $stable(last_of_run), "result beat changed while stalled")

  // one command in work at a time
  `PCCR_ASSERT_NEXT(a_one_cmd, in_valid && !in_stall, in_stall, "second command taken while one is in work")

  `PCCR_ASSERT_NOW(a_recv_shape, out_valid && accepted, !has_entry && last_of_run && dump_count == '0, "receive result carries entry or run data")

  // only a dump run produces a beat that is not the last
  `PCCR_ASSERT_NOW(a_run_shape, out_valid && !last_of_run, has_entry && dump_count != '0, "non-final beat outside a dump run")

endmodule

bind per_channel_command_ring_core pccr_checker u_pccr_checker (.*);
